>>> rtl/dotq_pkg.sv
// Shared types and constants for the deadline-ordered timer queue.
`default_nettype none
package dotq_pkg;

  localparam int unsigned HANDLE_W   = 16;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned MAX_FIRE   = 16;
  localparam int unsigned FIRE_CNT_W = 4;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_FIRED       = 2'd0,
    KIND_CANCEL_ACK  = 2'd1,
    KIND_ADD_DROPPED = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   deadline;
  } cell_data_t;

  typedef struct packed {
    cell_op_e            op;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   deadline;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/dotq_cell.sv
// One slot of the sorted timer chain with its insert and remove decisions.
`default_nettype none
module dotq_cell (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire dotq_pkg::cell_ctl_t  ctl,
  input  wire dotq_pkg::cell_data_t left_data,
  input  wire                    left_keep,
  input  wire dotq_pkg::cell_data_t right_data,
  input  wire                    match_in,
  output dotq_pkg::cell_data_t   data,
  output logic                   keep_out,
  output logic                   match_out
);
  import dotq_pkg::*;

  cell_data_t data_r;
  cell_data_t data_nxt;

  assign data      = data_r;
  assign keep_out  = data_r.valid && (data_r.deadline <= ctl.deadline);
  assign match_out = match_in || (data_r.valid && (data_r.handle == ctl.handle));

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_INS: begin
        if (!keep_out) begin
          if (left_keep) begin
            data_nxt.valid    = 1'b1;
            data_nxt.handle   = ctl.handle;
            data_nxt.deadline = ctl.deadline;
          end else begin
            data_nxt = left_data;
          end
        end
      end
      CELL_DEL: begin
        if (match_out) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.valid <= 1'b0;
    end else begin
      data_r.valid <= data_nxt.valid;
    end
    data_r.handle   <= data_nxt.handle;
    data_r.deadline <= data_nxt.deadline;
  end

endmodule
`default_nettype wire

>>> rtl/deadline_ordered_timer_queue.sv
// Top level of the deadline-ordered timer queue: command control and cell chain.
// The block keeps up to QUEUE_DEPTH timers in a chain of cells sorted by deadline,
// with earlier inserts ahead of later ones that share a deadline.
// Requests enter on the in_ channel; in_tuser carries the command and in_tdata
// the handle, the deadline and the current time.
// Results leave on the out_ channel from an output register; out_tuser carries
// the result kind and out_tlast marks the final result of a request.
// Add, cancel and stop requests are accepted in ST_IDLE and act on the chain in ST_EXEC.
// A tick with firing enabled passes through ST_EXEC into ST_FIRE, which ends at once
// when nothing is due; it fires at most sixteen timers, one per cycle from the head
// while the output register is free; the compares on the first two cells set that pace.
// An add that fits and a stop give no result; a cancel always gives one.
// A new request is accepted while an earlier result still waits in the output
// register, but no result is lost or overwritten while the receiver stalls:
// the chain and the command hold until the output register frees up.
// Reset empties the chain and enables firing; no clearing pass is needed.
`default_nettype none
module deadline_ordered_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [1:0]   in_tuser,   // cmd
  input  wire  [111:0] in_tdata,   // in_handle, deadline, current_time
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [1:0]   out_tuser,  // kind
  output logic [71:0]  out_tdata,  // out_handle, fired_deadline, found, zero fill
  output logic         out_tlast
);
  import dotq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIRE
  } state_t;

  state_t                state_r, state_nxt;
  cmd_e                  cmd_r, cmd_nxt;
  logic [HANDLE_W-1:0]   handle_r, handle_nxt;
  logic [TIME_W-1:0]     dl_r, dl_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic                  en_r, en_nxt;
  logic [FIRE_CNT_W-1:0] fire_cnt_r, fire_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  kind_e                 out_kind_r, out_kind_nxt;
  logic [HANDLE_W-1:0]   out_handle_r, out_handle_nxt;
  logic [TIME_W-1:0]     out_dl_r, out_dl_nxt;
  logic                  out_found_r, out_found_nxt;
  logic                  out_last_r, out_last_nxt;

  cell_ctl_t  ctl;
  logic       shift_all;
  cell_data_t cell_q   [QUEUE_DEPTH];
  logic       keep     [QUEUE_DEPTH];
  logic       match    [QUEUE_DEPTH];

  logic head_due;
  logic next_due;
  logic fire_last;
  logic out_free;
  logic full;
  logic found;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      cell_data_t left_d;
      cell_data_t right_d;
      logic       left_k;
      logic       match_i;
      if (gi == 0) begin : g_first
        assign left_d  = '0;
        assign left_k  = 1'b1;
        assign match_i = shift_all;
      end else begin : g_inner
        assign left_d  = cell_q[gi-1];
        assign left_k  = keep[gi-1];
        assign match_i = match[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_right
        assign right_d = cell_q[gi+1];
      end
      dotq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .left_data  (left_d),
        .left_keep  (left_k),
        .right_data (right_d),
        .match_in   (match_i),
        .data       (cell_q[gi]),
        .keep_out   (keep[gi]),
        .match_out  (match[gi])
      );
    end
  endgenerate

  assign head_due  = cell_q[0].valid && (cell_q[0].deadline <= now_r);
  assign next_due  = cell_q[1].valid && (cell_q[1].deadline <= now_r);
  assign fire_last = (fire_cnt_r == FIRE_CNT_W'(MAX_FIRE - 1)) || !next_due;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = cell_q[QUEUE_DEPTH-1].valid;
  assign found     = match[QUEUE_DEPTH-1];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_found_r, out_dl_r, out_handle_r};

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    handle_nxt     = handle_r;
    dl_nxt         = dl_r;
    now_nxt        = now_r;
    en_nxt         = en_r;
    fire_cnt_nxt   = fire_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_handle_nxt = out_handle_r;
    out_dl_nxt     = out_dl_r;
    out_found_nxt  = out_found_r;
    out_last_nxt   = out_last_r;
    ctl.op         = CELL_HOLD;
    ctl.handle     = handle_r;
    ctl.deadline   = dl_r;
    shift_all      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = cmd_e'(in_tuser);
          handle_nxt = in_tdata[15:0];
          dl_nxt     = in_tdata[63:16];
          now_nxt    = in_tdata[111:64];
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd_r)
          CMD_TICK: begin
            fire_cnt_nxt = '0;
            state_nxt    = en_r ? ST_FIRE : ST_IDLE;
          end
          CMD_ADD: begin
            if (full) begin
              if (out_free) begin
                out_valid_nxt  = 1'b1;
                out_kind_nxt   = KIND_ADD_DROPPED;
                out_handle_nxt = handle_r;
                out_dl_nxt     = '0;
                out_found_nxt  = 1'b0;
                out_last_nxt   = 1'b1;
                state_nxt      = ST_IDLE;
              end
            end else begin
              ctl.op    = CELL_INS;
              state_nxt = ST_IDLE;
            end
          end
          CMD_CANCEL: begin
            if (out_free) begin
              ctl.op         = CELL_DEL;
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_CANCEL_ACK;
              out_handle_nxt = handle_r;
              out_dl_nxt     = '0;
              out_found_nxt  = found;
              out_last_nxt   = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end
          CMD_STOP: begin
            en_nxt    = 1'b0;
            state_nxt = ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_FIRE: begin
        if (!head_due) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ctl.op         = CELL_DEL;
          shift_all      = 1'b1;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_FIRED;
          out_handle_nxt = cell_q[0].handle;
          out_dl_nxt     = cell_q[0].deadline;
          out_found_nxt  = 1'b0;
          out_last_nxt   = fire_last;
          fire_cnt_nxt   = fire_cnt_r + FIRE_CNT_W'(1);
          if (fire_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      en_r        <= 1'b1;
      out_valid_r <= 1'b0;
      fire_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
    end
    cmd_r        <= cmd_nxt;
    handle_r     <= handle_nxt;
    dl_r         <= dl_nxt;
    now_r        <= now_nxt;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_dl_r     <= out_dl_nxt;
    out_found_r  <= out_found_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
`default_nettype wire
